[src/assert_macros.svh]
// assertion macros shared by the clip stack modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[src/crs_pkg.sv]
// shared constants, types and command structs for the clip rectangle stack
package crs_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IN_CW       = 15;
  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 14;

  typedef logic signed [COORD_W-1:0] coord_t;

  // left edge in the low bits, top edge in the high bits
  typedef struct packed {
    coord_t top;
    coord_t right;
    coord_t bottom;
    coord_t left;
  } rect_t;

  typedef enum logic [0:0] {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    latch;
    logic    push;
    logic    pop;
    logic    set_status;
    status_t code;
    logic    load_out;
  } crs_cmd_t;

  typedef struct packed {
    logic req_pop;
    logic cnt_zero;
    logic cnt_full;
    logic out_free;
  } crs_stat_t;

endpackage

[src/crs_ctrl.sv]
// controller state machine sequencing each stack request
`include "assert_macros.svh"

module crs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output crs_pkg::crs_cmd_t   cmd,
  input  crs_pkg::crs_stat_t  stat
);
  import crs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_READ   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.code       = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        if (stat.req_pop) begin
          if (stat.cnt_zero) begin
            cmd.code = ST_EMPTY;
          end else begin
            cmd.pop = 1'b1;
          end
        end else if (stat.cnt_full) begin
          cmd.code = ST_FULL;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = S_READ;
      end
      // new top is read from the stack memory in this cycle
      S_READ: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMP(a_push_pop_excl, cmd.push, !cmd.pop)
  `ASSERT_NXT(a_load_to_idle, cmd.load_out, state_r == S_IDLE)

endmodule

[src/crs_datapath.sv]
// stack memory, rectangle intersection and result register
`include "assert_macros.svh"

module crs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crs_pkg::crs_cmd_t             cmd,
  output crs_pkg::crs_stat_t            stat,
  input  logic                          in_req_type,
  input  logic signed [crs_pkg::IN_CW-1:0]  in_rect_x,
  input  logic signed [crs_pkg::IN_CW-1:0]  in_rect_y,
  input  logic [crs_pkg::SIZE_W-1:0]    in_rect_w,
  input  logic [crs_pkg::SIZE_W-1:0]    in_rect_h,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_clip_enable,
  output logic signed [crs_pkg::COORD_W-1:0] out_clip_x,
  output logic signed [crs_pkg::COORD_W-1:0] out_clip_y,
  output logic [crs_pkg::SIZE_W-1:0]    out_clip_w,
  output logic [crs_pkg::SIZE_W-1:0]    out_clip_h,
  output logic [1:0]                    out_status
);
  import crs_pkg::*;

  rect_t               mem [STACK_DEPTH];
  rect_t               rd_r;
  rect_t               req_rect_r;
  req_t                req_r;
  logic [CNT_W-1:0]    cnt_r;
  status_t             status_r;
  status_t             out_st_r;
  logic                out_valid_r;
  logic                clip_en_r;
  coord_t              clip_x_r, clip_y_r;
  logic [SIZE_W-1:0]   clip_w_r, clip_h_r;

  coord_t              new_l, new_b;
  rect_t               push_word;
  logic                overlap;
  logic [PTR_W-1:0]    top_addr;
  coord_t              diff_w, diff_h;

  assign new_l = {in_rect_x[IN_CW-1], in_rect_x};
  assign new_b = {in_rect_y[IN_CW-1], in_rect_y};

  assign top_addr = PTR_W'(cnt_r - CNT_W'(1));

  assign stat.req_pop  = (req_r == REQ_POP);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_full = (cnt_r == CNT_W'(STACK_DEPTH));
  assign stat.out_free = !out_valid_r || !out_stall;

  // ranges overlap on both axes, touching edges included
  assign overlap = (req_rect_r.left <= rd_r.right) && (req_rect_r.right >= rd_r.left) &&
                   (req_rect_r.bottom <= rd_r.top) && (req_rect_r.top >= rd_r.bottom);

  always_comb begin
    if (stat.cnt_zero) begin
      push_word = req_rect_r;
    end else if (overlap) begin
      push_word.left   = (req_rect_r.left > rd_r.left) ? req_rect_r.left : rd_r.left;
      push_word.bottom = (req_rect_r.bottom > rd_r.bottom) ? req_rect_r.bottom : rd_r.bottom;
      push_word.right  = (req_rect_r.right < rd_r.right) ? req_rect_r.right : rd_r.right;
      push_word.top    = (req_rect_r.top < rd_r.top) ? req_rect_r.top : rd_r.top;
    end else begin
      push_word = '0;
    end
  end

  assign diff_w = rd_r.right - rd_r.left;
  assign diff_h = rd_r.top - rd_r.bottom;

  // stack memory: one write port, one registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[cnt_r[PTR_W-1:0]] <= push_word;
    end
    rd_r <= mem[top_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r             <= req_t'(in_req_type);
      req_rect_r.left   <= new_l;
      req_rect_r.bottom <= new_b;
      req_rect_r.right  <= new_l + {2'b00, in_rect_w};
      req_rect_r.top    <= new_b + {2'b00, in_rect_h};
    end
    if (cmd.set_status) begin
      status_r <= cmd.code;
    end
    if (cmd.load_out) begin
      // status travels with the result so a held result keeps its own code
      out_st_r <= status_r;
      if (stat.cnt_zero) begin
        clip_en_r <= 1'b0;
        clip_x_r  <= '0;
        clip_y_r  <= '0;
        clip_w_r  <= '0;
        clip_h_r  <= '0;
      end else begin
        clip_en_r <= 1'b1;
        clip_x_r  <= rd_r.left;
        clip_y_r  <= rd_r.bottom;
        clip_w_r  <= diff_w[SIZE_W-1:0];
        clip_h_r  <= diff_h[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (cmd.pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_clip_enable = clip_en_r;
  assign out_clip_x      = clip_x_r;
  assign out_clip_y      = clip_y_r;
  assign out_clip_w      = clip_w_r;
  assign out_clip_h      = clip_h_r;
  assign out_status      = out_st_r;

  `ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(STACK_DEPTH))
  `ASSERT_IMP(a_off_is_zero, out_valid_r && !clip_en_r, (clip_x_r == '0) && (clip_w_r == '0) && (clip_h_r == '0))

endmodule

[src/clip_rectangle_stack.sv]
// top level of the clip rectangle stack
// Keeps a stack of up to crs_pkg::STACK_DEPTH clip rectangles in a memory with one write port
// and one registered read; a push intersects the new rectangle with the top entry (an empty
// stack takes it as it is), a pop drops the top, and every request returns the active clip with
// a status code (push on full or pop on empty changes nothing). The top entry is read in the
// cycle the request is accepted; after that the request updates the stack, reads the new top
// and then loads the result into the output register, waiting there while a stalled consumer
// still holds the previous result. The next request is accepted in the cycle after the load,
// even while that result is still held by a stalled consumer; a request is only taken once the
// previous one is through, as the read-update-read sequence on the stack memory demands.
// Entries are only ever used after being written, so there is no clearing pass after reset.
module clip_rectangle_stack (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic signed [crs_pkg::IN_CW-1:0]   in_rect_x,
  input  logic signed [crs_pkg::IN_CW-1:0]   in_rect_y,
  input  logic [crs_pkg::SIZE_W-1:0]         in_rect_w,
  input  logic [crs_pkg::SIZE_W-1:0]         in_rect_h,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_clip_enable,
  output logic signed [crs_pkg::COORD_W-1:0] out_clip_x,
  output logic signed [crs_pkg::COORD_W-1:0] out_clip_y,
  output logic [crs_pkg::SIZE_W-1:0]         out_clip_w,
  output logic [crs_pkg::SIZE_W-1:0]         out_clip_h,
  output logic [1:0]                         out_status
);
  import crs_pkg::*;

  crs_cmd_t  cmd;
  crs_stat_t stat;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  crs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_rect_x       (in_rect_x),
    .in_rect_y       (in_rect_y),
    .in_rect_w       (in_rect_w),
    .in_rect_h       (in_rect_h),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clip_enable (out_clip_enable),
    .out_clip_x      (out_clip_x),
    .out_clip_y      (out_clip_y),
    .out_clip_w      (out_clip_w),
    .out_clip_h      (out_clip_h),
    .out_status      (out_status)
  );

endmodule
